/* design/kma_pkg.sv */
// Shared types and constants for the k-means assign and update block.
package kma_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_EMIT_PT,
      ST_UPD_RD,
      ST_UPD_DIV,
      ST_UPD_EMIT
   } state_type;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   localparam logic KIND_ASSIGN = 1'b0;
   localparam logic KIND_CENTER = 1'b1;

   localparam logic [1:0] REG_CENTER_COUNT = 2'b00;

endpackage

/* design/kmeans_assign_and_update.sv */
// Top level of the k-means assign and update block.
//
//  channel | direction | transaction
//  req     | in        | center load or data point (tuser = op, tlast = last_point)
//  rsp     | out       | point assignment or updated center (tuser = kind)
//  csr     | in        | APB write/read of the cluster count
//
// For a point, one center is read per cycle from the center memory, then the
// accumulator entry is read, updated and written before the output handshake.
// A last point adds, per center, a memory read, a latch step, a bit-serial
// divider run for x and y together and an emit step. A center load is written
// when it is accepted. Reset is synchronous; written-entry masks make unwritten
// centers and sums read as zero, and the sums' mask is dropped at the end of each
// pass, so the block accepts items right after reset. A stalled rsp holds the block.
module kmeans_assign_and_update #(
   parameter int MAX_CLUSTERS     = 32,
   parameter int COORD_BITS       = 16,
   parameter int PASS_POINTS_LOG2 = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // center_index[4:0], coord_x[20:5], coord_y[36:21], zero fill
   input  logic [39:0] req_tdata,
   // op[0]
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cluster[4:0], center_x[20:5], center_y[36:21], overflow[37], zero fill
   output logic [39:0] rsp_tdata,
   // kind[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_BITS = $clog2(MAX_CLUSTERS);
   localparam int ACC_BITS = COORD_BITS + PASS_POINTS_LOG2;
   localparam int CNT_BITS = PASS_POINTS_LOG2 + 1;
   localparam int DST_BITS = 2 * COORD_BITS + 1;
   localparam int DIV_STEPS = ACC_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS + 1);
   localparam int MEM_W = 2 * ACC_BITS + CNT_BITS;

   // Configuration register.
   logic [5:0] clusters_ff;
   logic       csr_write;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == kma_pkg::REG_CENTER_COUNT);
   assign csr_prdata = (csr_paddr == kma_pkg::REG_CENTER_COUNT) ?
                       {26'd0, clusters_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= 6'd10;
      end else if (csr_write) begin
         clusters_ff <= csr_pwdata[5:0];
      end
   end

   logic [IDX_BITS:0] k_eff;
   always_comb begin
      priority if (clusters_ff == 6'd0) begin
         k_eff = (IDX_BITS + 1)'(1);
      end else if (7'(clusters_ff) > 7'(MAX_CLUSTERS)) begin
         k_eff = (IDX_BITS + 1)'(MAX_CLUSTERS);
      end else begin
         k_eff = (IDX_BITS + 1)'(clusters_ff);
      end
   end

   // Input fields.
   logic                  in_op;
   logic [4:0]            in_idx;
   logic [COORD_BITS-1:0] in_x, in_y;
   assign in_op  = req_tuser;
   assign in_idx = req_tdata[4:0];
   assign in_x   = COORD_BITS'(req_tdata[20:5]);
   assign in_y   = COORD_BITS'(req_tdata[36:21]);

   // Center memory: {x, y}. Accumulator memory: {acc_x, acc_y, count}.
   logic [2*COORD_BITS-1:0] ctr_mem [MAX_CLUSTERS];
   logic [MEM_W-1:0]        acc_mem [MAX_CLUSTERS];
   logic [2*COORD_BITS-1:0] ctr_rd_ff;
   logic [MEM_W-1:0]        acc_rd_ff;
   logic [IDX_BITS-1:0]     ctr_raddr, acc_raddr, ctr_waddr, acc_waddr;
   logic                    ctr_we, acc_we;
   logic [2*COORD_BITS-1:0] ctr_wdata;
   logic [MEM_W-1:0]        acc_wdata;
   logic [MAX_CLUSTERS-1:0] ctr_written_ff;
   logic                    ctr_rd_valid_ff;
   logic [MAX_CLUSTERS-1:0] acc_written_ff;
   logic                    acc_rd_valid_ff;
   logic                    acc_clear;

   always_ff @(posedge clock) begin
      if (ctr_we) begin
         ctr_mem[ctr_waddr] <= ctr_wdata;
      end
      ctr_rd_ff <= ctr_mem[ctr_raddr];
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   // Centers and sums reset to zero: track written entries. Dropping the sums'
   // mask at the end of a pass makes every sum and count read as zero again.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_written_ff  <= '0;
         ctr_rd_valid_ff <= 1'b0;
         acc_written_ff  <= '0;
         acc_rd_valid_ff <= 1'b0;
      end else begin
         if (ctr_we) begin
            ctr_written_ff[ctr_waddr] <= 1'b1;
         end
         ctr_rd_valid_ff <= ctr_written_ff[ctr_raddr];
         if (acc_clear) begin
            acc_written_ff <= '0;
         end else if (acc_we) begin
            acc_written_ff[acc_waddr] <= 1'b1;
         end
         acc_rd_valid_ff <= acc_written_ff[acc_raddr];
      end
   end

   logic [COORD_BITS-1:0] cx_rd, cy_rd;
   assign cx_rd = ctr_rd_valid_ff ? ctr_rd_ff[2*COORD_BITS-1:COORD_BITS] : '0;
   assign cy_rd = ctr_rd_valid_ff ? ctr_rd_ff[COORD_BITS-1:0] : '0;

   logic [ACC_BITS-1:0] ax_rd, ay_rd;
   logic [CNT_BITS-1:0] cnt_rd;
   assign ax_rd  = acc_rd_valid_ff ? acc_rd_ff[MEM_W-1 -: ACC_BITS] : '0;
   assign ay_rd  = acc_rd_valid_ff ? acc_rd_ff[CNT_BITS +: ACC_BITS] : '0;
   assign cnt_rd = acc_rd_valid_ff ? acc_rd_ff[CNT_BITS-1:0] : '0;

   // Control and datapath registers.
   kma_pkg::state_type    state_ff, state_in;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic                  last_ff;
   logic [IDX_BITS:0]     j_ff, j_in;
   logic [IDX_BITS-1:0]   best_ff, best_in;
   logic [DST_BITS-1:0]   best_d_ff, best_d_in;
   logic [CNT_BITS-1:0]   pass_points_ff, pass_points_in;
   logic                  pass_ovf_ff, pass_ovf_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [ACC_BITS-1:0]   qx_ff, qx_in, qy_ff, qy_in;
   logic [CNT_BITS-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [CNT_BITS-1:0]   div_ff, div_in;
   logic [COORD_BITS-1:0] ocx_ff, ocx_in, ocy_ff, ocy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [4:0]            rsp_cl_ff, rsp_cl_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_end_ff, rsp_end_in;

   // Squared distance to the center read this cycle.
   logic [COORD_BITS-1:0] dx, dy;
   logic [DST_BITS-1:0]   dist_sq;
   assign dx      = (px_ff > cx_rd) ? px_ff - cx_rd : cx_rd - px_ff;
   assign dy      = (py_ff > cy_rd) ? py_ff - cy_rd : cy_rd - py_ff;
   assign dist_sq = DST_BITS'(dx * dx) + DST_BITS'(dy * dy);

   // Restoring divider steps for x and y.
   logic [CNT_BITS:0]   trial_x, trial_y;
   assign trial_x = {rx_ff, qx_ff[ACC_BITS-1]} - {1'b0, div_ff};
   assign trial_y = {ry_ff, qy_ff[ACC_BITS-1]} - {1'b0, div_ff};

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      j_in           = j_ff;
      best_in        = best_ff;
      best_d_in      = best_d_ff;
      pass_points_in = pass_points_ff;
      pass_ovf_in    = pass_ovf_ff;
      step_in        = step_ff;
      qx_in          = qx_ff;
      qy_in          = qy_ff;
      rx_in          = rx_ff;
      ry_in          = ry_ff;
      div_in         = div_ff;
      ocx_in         = ocx_ff;
      ocy_in         = ocy_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_cl_in      = rsp_cl_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_end_in     = rsp_end_ff;
      req_tready     = 1'b0;
      ctr_raddr      = '0;
      acc_raddr      = best_ff;
      ctr_we         = 1'b0;
      ctr_waddr      = in_idx[IDX_BITS-1:0];
      ctr_wdata      = {in_x, in_y};
      acc_we         = 1'b0;
      acc_waddr      = best_ff;
      acc_wdata      = '0;
      acc_clear      = 1'b0;

      unique case (state_ff)
         kma_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (in_op == kma_pkg::OP_LOAD) begin
                  ctr_we = 6'(in_idx) < 6'(MAX_CLUSTERS);
               end else begin
                  ctr_raddr = '0;
                  j_in      = (IDX_BITS + 1)'(1);
                  state_in  = kma_pkg::ST_SCAN;
               end
            end
         end
         kma_pkg::ST_SCAN: begin
            // Data for center j-1 arrives; issue read of center j.
            ctr_raddr = j_ff[IDX_BITS-1:0];
            if (j_ff == (IDX_BITS + 1)'(1) || dist_sq < best_d_ff) begin
               best_d_in = dist_sq;
               best_in   = IDX_BITS'(j_ff - 1'b1);
            end
            if (j_ff == k_eff) begin
               state_in = kma_pkg::ST_ACC_RD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         kma_pkg::ST_ACC_RD: begin
            acc_raddr = best_ff;
            state_in  = kma_pkg::ST_ACC_WR;
         end
         kma_pkg::ST_ACC_WR: begin
            if (pass_points_ff[CNT_BITS-1]) begin
               pass_ovf_in = 1'b1;
            end else begin
               pass_points_in = pass_points_ff + 1'b1;
               acc_we    = 1'b1;
               acc_wdata = {ax_rd + ACC_BITS'(px_ff),
                            ay_rd + ACC_BITS'(py_ff), cnt_rd + 1'b1};
            end
            state_in = kma_pkg::ST_EMIT_PT;
         end
         kma_pkg::ST_EMIT_PT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kma_pkg::KIND_ASSIGN;
               rsp_cl_in    = 5'(best_ff);
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_ovf_in   = pass_ovf_ff;
               rsp_end_in   = !last_ff;
               j_in         = '0;
               state_in     = last_ff ? kma_pkg::ST_UPD_RD : kma_pkg::ST_IDLE;
            end
         end
         kma_pkg::ST_UPD_RD: begin
            ctr_raddr = j_ff[IDX_BITS-1:0];
            acc_raddr = j_ff[IDX_BITS-1:0];
            step_in   = '0;
            state_in  = kma_pkg::ST_SCAN_LAST;
         end
         kma_pkg::ST_SCAN_LAST: begin
            // Latch the read data and start the divider.
            qx_in  = ax_rd;
            qy_in  = ay_rd;
            rx_in  = '0;
            ry_in  = '0;
            div_in = cnt_rd;
            ocx_in = cx_rd;
            ocy_in = cy_rd;
            state_in = kma_pkg::ST_UPD_DIV;
         end
         kma_pkg::ST_UPD_DIV: begin
            if (trial_x[CNT_BITS]) begin
               rx_in = {rx_ff[CNT_BITS-2:0], qx_ff[ACC_BITS-1]};
               qx_in = {qx_ff[ACC_BITS-2:0], 1'b0};
            end else begin
               rx_in = trial_x[CNT_BITS-1:0];
               qx_in = {qx_ff[ACC_BITS-2:0], 1'b1};
            end
            if (trial_y[CNT_BITS]) begin
               ry_in = {ry_ff[CNT_BITS-2:0], qy_ff[ACC_BITS-1]};
               qy_in = {qy_ff[ACC_BITS-2:0], 1'b0};
            end else begin
               ry_in = trial_y[CNT_BITS-1:0];
               qy_in = {qy_ff[ACC_BITS-2:0], 1'b1};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = kma_pkg::ST_UPD_EMIT;
            end
         end
         kma_pkg::ST_UPD_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kma_pkg::KIND_CENTER;
               rsp_cl_in    = 5'(j_ff);
               rsp_ovf_in   = pass_ovf_ff;
               rsp_end_in   = (j_ff + 1'b1) == k_eff;
               if (div_ff != '0) begin
                  rsp_x_in  = qx_ff[COORD_BITS-1:0];
                  rsp_y_in  = qy_ff[COORD_BITS-1:0];
                  ctr_we    = 1'b1;
                  ctr_waddr = j_ff[IDX_BITS-1:0];
                  ctr_wdata = {qx_ff[COORD_BITS-1:0], qy_ff[COORD_BITS-1:0]};
               end else begin
                  rsp_x_in  = ocx_ff;
                  rsp_y_in  = ocy_ff;
               end
               if ((j_ff + 1'b1) == k_eff) begin
                  // Every sum and count reads as zero from here on.
                  acc_clear      = 1'b1;
                  pass_points_in = '0;
                  pass_ovf_in    = 1'b0;
                  state_in       = kma_pkg::ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = kma_pkg::ST_UPD_RD;
               end
            end
         end
         default: begin
            state_in = kma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= kma_pkg::ST_IDLE;
         pass_points_ff <= '0;
         pass_ovf_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pass_points_ff <= pass_points_in;
         pass_ovf_ff    <= pass_ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == kma_pkg::ST_IDLE && req_tvalid && in_op == kma_pkg::OP_POINT) begin
         px_ff   <= in_x;
         py_ff   <= in_y;
         last_ff <= req_tlast;
      end
      j_ff      <= j_in;
      best_ff   <= best_in;
      best_d_ff <= best_d_in;
      step_ff   <= step_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      div_ff    <= div_in;
      ocx_ff    <= ocx_in;
      ocy_ff    <= ocy_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_cl_ff   <= rsp_cl_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tdata  = {2'd0, rsp_ovf_ff, 16'(rsp_y_ff), 16'(rsp_x_ff), rsp_cl_ff};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == kma_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == kma_pkg::ST_UPD_EMIT |-> step_ff == STEP_BITS'(DIV_STEPS))
      else $error("divider emitted early");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the k-means assign and update block.
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic       op;
      logic [4:0] index;
      logic [15:0] x;
      logic [15:0] y;
      logic       last;
   } item_type;

   typedef struct packed {
      logic       kind;
      logic [4:0] cluster;
      logic [15:0] cx;
      logic [15:0] cy;
      logic       ovf;
      logic       run_end;
   } result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   kmeans_assign_and_update uut (.*);

   // Predictor state.
   logic [5:0]  k_reg;
   logic [15:0] cen_x [32];
   logic [15:0] cen_y [32];
   logic [35:0] sum_x [32];
   logic [35:0] sum_y [32];
   logic [20:0] members [32];
   logic [20:0] points_in_pass;
   logic        pass_ovf;

   item_type   pending_items[$];
   result_type expected_results[$];
   int      errors;
   int      checked;
   int      centers_seen;
   bit      idle_on;
   bit      hold_rsp;
   int      send_gap;
   int      recv_gap;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int active_centers();
      if (k_reg == 0) return 1;
      if (k_reg > 32) return 32;
      return k_reg;
   endfunction

   function automatic logic [33:0] dist2(logic [15:0] ax, logic [15:0] ay,
                                          logic [15:0] bx, logic [15:0] by);
      logic [15:0] dx;
      logic [15:0] dy;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      return 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
   endfunction

   task automatic predict_cluster(item_type it);
      int k;
      int best;
      logic [33:0] best_d;
      logic [33:0] d;
      result_type r;
      k = active_centers();
      best = 0;
      if (it.op == kma_pkg::OP_LOAD) begin
         cen_x[it.index] = it.x;
         cen_y[it.index] = it.y;
         return;
      end
      best_d = dist2(it.x, it.y, cen_x[0], cen_y[0]);
      for (int j = 1; j < k; j++) begin
         d = dist2(it.x, it.y, cen_x[j], cen_y[j]);
         if (d < best_d) begin
            best_d = d;
            best = j;
         end
      end
      if (points_in_pass[20]) begin
         pass_ovf = 1'b1;
      end else begin
         points_in_pass++;
         sum_x[best] += it.x;
         sum_y[best] += it.y;
         members[best]++;
      end
      r = '{kma_pkg::KIND_ASSIGN, best[4:0], 16'd0, 16'd0, pass_ovf, !it.last};
      expected_results = {expected_results, r};
      if (!it.last) return;
      for (int j = 0; j < k; j++) begin
         if (members[j] != 0) begin
            cen_x[j] = 16'(sum_x[j] / members[j]);
            cen_y[j] = 16'(sum_y[j] / members[j]);
         end
         r = '{kma_pkg::KIND_CENTER, j[4:0], cen_x[j], cen_y[j], pass_ovf, j + 1 == k};
         expected_results = {expected_results, r};
      end
      for (int j = 0; j < 32; j++) begin
         sum_x[j] = '0;
         sum_y[j] = '0;
         members[j] = '0;
      end
      points_in_pass = '0;
      pass_ovf = 1'b0;
   endtask

   task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
      errors++;
      $display("Mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // Driver: takes the next pending item and predicts it when it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         req_tlast <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_cluster(pending_items.pop_front());
         if (req_tvalid && !req_tready) begin
            // keep offering the same item
         end else if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_items.size() > 0) begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
               req_tvalid <= 1'b0;
               send_gap <= $urandom_range(1, 12) - 1;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= {3'b0, pending_items[0].y, pending_items[0].x,
                             pending_items[0].index};
               req_tuser <= pending_items[0].op;
               req_tlast <= pending_items[0].last;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: compares each result transaction with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[4:0], rsp_tdata[20:5], rsp_tdata[36:21],
                    rsp_tdata[37], rsp_tlast};
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 40'(got), 40'd0);
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (got.kind) centers_seen++;
               if (got.kind != want.kind)
                  report_mismatch("kind", 40'(got.kind), 40'(want.kind));
               if (got.cluster != want.cluster)
                  report_mismatch("cluster", 40'(got.cluster), 40'(want.cluster));
               if (got.cx != want.cx)
                  report_mismatch("center_x", 40'(got.cx), 40'(want.cx));
               if (got.cy != want.cy)
                  report_mismatch("center_y", 40'(got.cy), 40'(want.cy));
               if (got.ovf != want.ovf)
                  report_mismatch("overflow", 40'(got.ovf), 40'(want.ovf));
               if (got.run_end != want.run_end)
                  report_mismatch("run_end", 40'(got.run_end), 40'(want.run_end));
            end
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            rsp_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            recv_gap <= $urandom_range(1, 12) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [5:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= kma_pkg::REG_CENTER_COUNT;
      csr_pwdata <= {26'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      k_reg = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      // A trailing center load produces no result; give it time to land.
      repeat (10) @(posedge clock);
   endtask

   function automatic item_type make_item(logic op, logic [4:0] idx, logic [15:0] x,
                                          logic [15:0] y, logic last);
      item_type it;
      it = '{op, idx, x, y, last};
      return it;
   endfunction

   task automatic enqueue_item(item_type it);
      pending_items = {pending_items, it};
   endtask

   task automatic queue_pass(int n_centers, int n_points);
      for (int j = 0; j < n_centers; j++)
         enqueue_item(make_item(kma_pkg::OP_LOAD, j[4:0], 16'($urandom), 16'($urandom),
                                1'($urandom_range(0, 1))));
      for (int j = 0; j < n_points; j++)
         enqueue_item(make_item(kma_pkg::OP_POINT, 5'($urandom), 16'($urandom),
                                16'($urandom), j == n_points - 1));
   endtask

   initial begin
      int k_choices[6];
      k_choices = '{1, 32, 0, 40, 3, 7};
      errors = 0;
      checked = 0;
      centers_seen = 0;
      idle_on = 1'b1;
      hold_rsp = 1'b0;
      k_reg = 6'd10;
      for (int j = 0; j < 32; j++) begin
         cen_x[j] = '0;
         cen_y[j] = '0;
         sum_x[j] = '0;
         sum_y[j] = '0;
         members[j] = '0;
      end
      points_in_pass = '0;
      pass_ovf = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, tie between equal centers, empty clusters, ignored tlast on load.
      csr_write(6'd4);
      enqueue_item(make_item(kma_pkg::OP_LOAD, 5'd0, 16'd0, 16'd0, 1'b1));
      enqueue_item(make_item(kma_pkg::OP_LOAD, 5'd1, 16'hFFFF, 16'hFFFF, 1'b0));
      enqueue_item(make_item(kma_pkg::OP_LOAD, 5'd2, 16'd100, 16'd100, 1'b0));
      enqueue_item(make_item(kma_pkg::OP_LOAD, 5'd3, 16'd100, 16'd100, 1'b0));
      enqueue_item(make_item(kma_pkg::OP_LOAD, 5'd31, 16'h8000, 16'h7FFF, 1'b0));
      enqueue_item(make_item(kma_pkg::OP_POINT, 5'd31, 16'hFFFF, 16'hFFFF, 1'b0));
      enqueue_item(make_item(kma_pkg::OP_POINT, 5'd0, 16'd0, 16'd0, 1'b0));
      enqueue_item(make_item(kma_pkg::OP_POINT, 5'd0, 16'd101, 16'd99, 1'b0));
      enqueue_item(make_item(kma_pkg::OP_POINT, 5'd0, 16'hFFFE, 16'hFFFF, 1'b0));
      enqueue_item(make_item(kma_pkg::OP_POINT, 5'd0, 16'h7FFF, 16'h8000, 1'b1));
      enqueue_item(make_item(kma_pkg::OP_POINT, 5'd0, 16'd3, 16'd5, 1'b1));
      wait_drained();

      // Long receiver hold: the block must fill and stall its input.
      csr_write(6'd2);
      hold_rsp = 1'b1;
      queue_pass(2, 8);
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();

      // Random passes over several register settings, extremes included.
      for (int p = 0; p < 6; p++) begin
         csr_write(k_choices[p][5:0]);
         queue_pass($urandom_range(1, 12), (p == 1) ? 6 : $urandom_range(8, 14));
         wait_drained();
      end
      idle_on = 1'b0;
      csr_write(6'd5);
      queue_pass(5, 25);
      wait_drained();

      $display("Checked %0d results, %0d of them updated centers.", checked, centers_seen);
      $display("Covered register values 0..40, center loads and passes with stalls.");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
